@@ rtl/core/fixed_16_16_saturating_alu_top_macros.svh @@
// Assertion macros for the fixed-point ALU.
`ifndef FIXED_16_16_SATURATING_ALU_TOP_MACROS_SVH
`define FIXED_16_16_SATURATING_ALU_TOP_MACROS_SVH

// checked only outside reset
`define Q16_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define Q16_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/q16alu_pkg.sv @@
// Shared types and constants of the 16.16 fixed-point ALU.
package q16alu_pkg;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_FLR  = 3'd4;
    localparam logic [2:0] CMD_CEIL = 3'd5;
    localparam logic [2:0] CMD_I2F  = 3'd6;
    localparam logic [2:0] CMD_F2I  = 3'd7;

    localparam logic [31:0] POS_SAT  = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_SAT  = 32'h8000_0001;
    localparam logic [31:0] MIN_VAL  = 32'h8000_0000;
    localparam logic [31:0] CEIL_SAT = 32'h0000_7FFF;
    localparam logic [31:0] CEIL_LIM = 32'h7FFF_0000;
    localparam logic [31:0] FRAC_ONE = 32'h0000_FFFF;
    localparam logic signed [63:0] MUL_BOUND = 64'sh0000_7FFF_FFFF_0000;

    // one quotient bit per divider stage
    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] a;
        logic [31:0] b;
    } t_p1;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [63:0] prod;
        logic [31:0]        ma;
        logic [31:0]        mb;
        logic               an;
        logic               bn;
        logic               bz;
        logic [31:0]        res;
        logic               err;
    } t_p2;

    typedef struct packed {
        logic        is_div;
        logic        neg;
        logic [31:0] res;
        logic        err;
        logic [32:0] rem;
        logic [31:0] dvd;
        logic [31:0] mb;
        logic [31:0] q;
    } t_stage;

endpackage

@@ rtl/core/q16alu_if.sv @@
// Stream channels of the fixed-point ALU: operation in, result out.
interface q16alu_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output cmd, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input cmd, input operand_a, input operand_b,
                    output ready);
endinterface

interface q16alu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               range_error;

    modport source (output valid, output result, output range_error, input ready);
    modport sink   (input valid, input result, input range_error, output ready);
endinterface

@@ rtl/core/fixed_16_16_saturating_alu_top.sv @@
// Every opcode takes the same path from input transfer to result valid: the setup
// stages, 32 restoring-divider stages and one output stage.
// Throughput: one operation per cycle; the whole pipe holds when the output
// register is full and not taken. Divider depth sets the latency.
// Reset (synchronous, active low) clears all stage valid bits.
module fixed_16_16_saturating_alu_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    q16alu_in_if.sink    i_in,
    q16alu_out_if.source o_out
);
    import q16alu_pkg::*;
    `include "fixed_16_16_saturating_alu_top_macros.svh"

    logic en;

    logic r_p1_vld, r_p2_vld, r_out_vld;
    t_p1  r_p1;
    t_p2  r_p2, n_p2;
    t_stage r_st [0:DIV_STEPS];
    t_stage n_st [0:DIV_STEPS];
    logic   r_vld [0:DIV_STEPS];
    logic [31:0] r_out_res, n_out_res;
    logic        r_out_err, n_out_err;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld <= i_in.valid;
        end
        if (en) begin
            r_p1.cmd <= i_in.cmd;
            r_p1.a   <= i_in.operand_a;
            r_p1.b   <= i_in.operand_b;
        end
    end

    // stage 2: product, magnitudes, simple ops
    always_comb begin
        logic [31:0] t;
        logic        ap, bp;
        n_p2.cmd  = r_p1.cmd;
        n_p2.prod = $signed(r_p1.a) * $signed(r_p1.b);
        n_p2.an   = r_p1.a[31];
        n_p2.bn   = r_p1.b[31];
        n_p2.bz   = (r_p1.b == 32'd0);
        n_p2.ma   = r_p1.a[31] ? (~r_p1.a + 32'd1) : r_p1.a;
        n_p2.mb   = r_p1.b[31] ? (~r_p1.b + 32'd1) : r_p1.b;
        ap = !r_p1.a[31] && (r_p1.a != 32'd0);
        bp = !r_p1.b[31] && (r_p1.b != 32'd0);
        n_p2.res = 32'd0;
        n_p2.err = 1'b0;
        t = 32'd0;
        unique case (r_p1.cmd)
            CMD_ADD: begin
                t = r_p1.a + r_p1.b;
                n_p2.res = t;
                if (r_p1.a[31] && r_p1.b[31] && !t[31]) begin
                    n_p2.res = NEG_SAT; n_p2.err = 1'b1;
                end else if (ap && bp && t[31]) begin
                    n_p2.res = POS_SAT; n_p2.err = 1'b1;
                end
            end
            CMD_SUB: begin
                t = r_p1.a - r_p1.b;
                n_p2.res = t;
                if (r_p1.a[31] && bp && !t[31]) begin
                    n_p2.res = NEG_SAT; n_p2.err = 1'b1;
                end else if (ap && r_p1.b[31] && t[31]) begin
                    n_p2.res = POS_SAT; n_p2.err = 1'b1;
                end
            end
            CMD_FLR: n_p2.res = {{16{r_p1.a[31]}}, r_p1.a[31:16]};
            CMD_CEIL: begin
                if (!r_p1.a[31] && (r_p1.a > CEIL_LIM)) begin
                    n_p2.res = CEIL_SAT; n_p2.err = 1'b1;
                end else begin
                    t = r_p1.a + FRAC_ONE;
                    n_p2.res = {{16{t[31]}}, t[31:16]};
                end
            end
            CMD_I2F: n_p2.res = {r_p1.a[15:0], 16'd0};
            CMD_F2I: n_p2.res = {{16{r_p1.a[31]}}, r_p1.a[31:16]} + {31'd0, r_p1.a[15]};
            CMD_MUL, CMD_DIV: n_p2.res = 32'd0;
            default: n_p2.res = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (en) begin
            r_p2_vld <= r_p1_vld;
        end
        if (en) begin
            r_p2 <= n_p2;
        end
    end

    // stage 3: multiply clamp, divide range check and divider setup
    always_comb begin
        logic [46:0] lim;
        logic        ovf;
        lim = {r_p2.mb, 15'd0} - {15'd0, r_p2.mb};
        ovf = {15'd0, r_p2.ma} > lim;
        n_st[0].neg    = (r_p2.an != r_p2.bn) && (r_p2.ma != 32'd0);
        n_st[0].is_div = 1'b0;
        n_st[0].res    = r_p2.res;
        n_st[0].err    = r_p2.err;
        n_st[0].rem    = {17'd0, r_p2.ma[31:16]};
        n_st[0].dvd    = {r_p2.ma[15:0], 16'd0};
        n_st[0].mb     = r_p2.mb;
        n_st[0].q      = 32'd0;
        if (r_p2.cmd == CMD_MUL) begin
            if (r_p2.prod > MUL_BOUND) begin
                n_st[0].res = POS_SAT; n_st[0].err = 1'b1;
            end else if (r_p2.prod < -MUL_BOUND) begin
                n_st[0].res = MIN_VAL; n_st[0].err = 1'b1;
            end else begin
                n_st[0].res = r_p2.prod[47:16];
            end
        end else if (r_p2.cmd == CMD_DIV) begin
            if (r_p2.bz) begin
                n_st[0].res = r_p2.an ? NEG_SAT : POS_SAT;
                n_st[0].err = 1'b1;
            end else if (ovf) begin
                n_st[0].res = n_st[0].neg ? NEG_SAT : POS_SAT;
                n_st[0].err = 1'b1;
            end else begin
                n_st[0].is_div = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= r_p2_vld;
        end
        if (en) begin
            r_st[0] <= n_st[0];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        always_comb begin
            logic [32:0] rem2;
            logic        ge;
            rem2 = {r_st[k].rem[31:0], r_st[k].dvd[31]};
            ge   = rem2 >= {1'b0, r_st[k].mb};
            n_st[k+1]     = r_st[k];
            n_st[k+1].rem = ge ? (rem2 - {1'b0, r_st[k].mb}) : rem2;
            n_st[k+1].dvd = {r_st[k].dvd[30:0], 1'b0};
            n_st[k+1].q   = {r_st[k].q[30:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (en) begin
                r_st[k+1] <= n_st[k+1];
            end
        end
    end

    // output stage: round half away from zero, apply sign
    always_comb begin
        logic [31:0] qr;
        logic        rnd;
        rnd = {r_st[DIV_STEPS].rem[31:0], 1'b0} >= {1'b0, r_st[DIV_STEPS].mb};
        qr  = r_st[DIV_STEPS].q + {31'd0, rnd};
        n_out_err = r_st[DIV_STEPS].err;
        if (r_st[DIV_STEPS].is_div) begin
            n_out_res = r_st[DIV_STEPS].neg ? (~qr + 32'd1) : qr;
        end else begin
            n_out_res = r_st[DIV_STEPS].res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[DIV_STEPS];
        end
        if (en) begin
            r_out_res <= n_out_res;
            r_out_err <= n_out_err;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.result      = r_out_res;
    assign o_out.range_error = r_out_err;

    `Q16_ASSERT_RST(a_rst_clears, !i_rst_n |=> !o_out.valid, "output valid after reset")
    `Q16_ASSERT(a_err_code, o_out.valid && o_out.range_error |-> (o_out.result == POS_SAT || o_out.result == NEG_SAT || o_out.result == MIN_VAL || o_out.result == CEIL_SAT), "range error with unsaturated result")
    `Q16_ASSERT(a_div_entry, r_vld[0] && en |=> r_vld[1], "item lost entering divider")

endmodule
